// ===== rtl/mbrc_pkg.sv =====
// Shared types and constants for the Modbus ASCII response checker.
`timescale 1ns / 1ps

package mbrc_pkg;

  localparam int MaxWords   = 125;
  localparam int QueueDepth = 2;

  // request codes on the input channel
  localparam logic [1:0] REQ_ARM  = 2'd0;
  localparam logic [1:0] REQ_CHAR = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_LRC     = 3'd1;
  localparam logic [2:0] ST_TIMEOUT = 3'd2;
  localparam logic [2:0] ST_FRAMING = 3'd3;
  localparam logic [2:0] ST_SLAVE   = 3'd4;
  localparam logic [2:0] ST_ECHO    = 3'd5;
  localparam logic [2:0] ST_FUNC    = 3'd6;

  // configuration register indexes
  localparam logic [2:0] REG_SLAVE    = 3'd0;
  localparam logic [2:0] REG_FUNCTION = 3'd1;
  localparam logic [2:0] REG_KIND     = 3'd2;
  localparam logic [2:0] REG_COUNT    = 3'd3;
  localparam logic [2:0] REG_REGISTER = 3'd4;
  localparam logic [2:0] REG_TIMEOUT  = 3'd5;

  typedef enum logic [2:0] {
    CLS_IGNORE,
    CLS_ARM,
    CLS_TICK,
    CLS_COLON,
    CLS_LF,
    CLS_CR,
    CLS_HEX,
    CLS_BAD
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [3:0] nib;
  } item_t;

  typedef struct packed {
    logic [7:0]  expected_slave;
    logic [7:0]  expected_function;
    logic        response_kind;
    logic [15:0] expected_count_or_value;
    logic [15:0] expected_register;
    logic [15:0] timeout_ms;
  } cfg_t;

endpackage

// ===== rtl/mbrc_if.sv =====
// Valid/ready channel interfaces for request and response beats.
`timescale 1ns / 1ps

interface mbrc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] rx_char;

  modport source(output valid, req_type, rx_char, input ready);
  modport sink(input valid, req_type, rx_char, output ready);
endinterface

interface mbrc_out_if;
  logic        valid;
  logic        ready;
  logic        is_status;
  logic [15:0] word_value;
  logic [6:0]  word_index;
  logic [2:0]  status;
  logic        last;

  modport source(output valid, is_status, word_value, word_index, status, last, input ready);
  modport sink(input valid, is_status, word_value, word_index, status, last, output ready);
endinterface

// ===== rtl/mbrc_front.sv =====
// Front end: accepts request beats, classifies characters, queues them.
`timescale 1ns / 1ps

module mbrc_front import mbrc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  mbrc_in_if.sink   req,
  output logic      q_valid,
  output item_t     q_item,
  input  logic      q_pop
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  item_t            cls_item;
  item_t            q_mem [QueueDepth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             push;

  always_comb begin
    cls_item.nib = 4'd0;
    cls_item.cls = CLS_IGNORE;
    unique case (req.req_type)
      REQ_ARM:  cls_item.cls = CLS_ARM;
      REQ_TICK: cls_item.cls = CLS_TICK;
      REQ_CHAR: begin
        priority if (req.rx_char == 8'h3A) cls_item.cls = CLS_COLON;
        else if (req.rx_char == 8'h0A) cls_item.cls = CLS_LF;
        else if (req.rx_char == 8'h0D) cls_item.cls = CLS_CR;
        else if (req.rx_char >= 8'h30 && req.rx_char <= 8'h39) begin
          cls_item.cls = CLS_HEX;
          cls_item.nib = req.rx_char[3:0];
        end else if (req.rx_char >= 8'h41 && req.rx_char <= 8'h46) begin
          cls_item.cls = CLS_HEX;
          cls_item.nib = req.rx_char[3:0] + 4'd9;
        end else cls_item.cls = CLS_BAD;
      end
      default: cls_item.cls = CLS_IGNORE;
    endcase
  end

  assign req.ready = (count != CntW'(QueueDepth));
  assign push      = req.valid && req.ready;
  assign q_valid   = (count != '0);
  assign q_item    = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cls_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/mbrc_back.sv =====
// Back end: frame decoder, checks, LRC sum, timeout and result register.
`timescale 1ns / 1ps

module mbrc_back import mbrc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_pop,
  mbrc_out_if.source rsp
);

  logic        armed, armed_next;
  logic        in_frame, in_frame_next;
  logic        nibble_pending, nibble_pending_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [7:0]  byte_position, byte_position_next;
  logic [7:0]  lrc_sum, lrc_sum_next;
  logic [7:0]  word_high_byte, word_high_byte_next;
  logic [2:0]  first_error, first_error_next;
  logic        framing_bad, framing_bad_next;
  logic [15:0] wait_counter, wait_counter_next;

  logic        out_valid;
  logic        res_valid;
  logic        res_is_status;
  logic [15:0] res_word;
  logic [6:0]  res_index;
  logic [2:0]  res_status;

  logic [7:0]  b;
  logic [15:0] q;
  logic        q_ok;
  logic [7:0]  p_off;
  logic [17:0] want;
  logic        len_bad;

  assign q_pop     = q_valid && (!out_valid || rsp.ready);
  assign b         = {high_nibble, q_item.nib};
  assign q         = cfg.expected_count_or_value;
  assign q_ok      = (q != 16'd0) && (q <= 16'(MaxWords));
  assign p_off     = byte_position - 8'd3;
  assign want      = cfg.response_kind ? 18'd7 : 18'd4 + {1'b0, q, 1'b0};
  assign len_bad   = ({10'd0, byte_position} != want);

  always_comb begin
    armed_next          = armed;
    in_frame_next       = in_frame;
    nibble_pending_next = nibble_pending;
    high_nibble_next    = high_nibble;
    byte_position_next  = byte_position;
    lrc_sum_next        = lrc_sum;
    word_high_byte_next = word_high_byte;
    first_error_next    = first_error;
    framing_bad_next    = framing_bad;
    wait_counter_next   = wait_counter;
    res_valid           = 1'b0;
    res_is_status       = 1'b0;
    res_word            = 16'd0;
    res_index           = 7'd0;
    res_status          = ST_OK;

    if (q_pop) begin
      if (q_item.cls == CLS_ARM) begin
        armed_next          = 1'b1;
        in_frame_next       = 1'b0;
        nibble_pending_next = 1'b0;
        framing_bad_next    = 1'b0;
        high_nibble_next    = 4'd0;
        byte_position_next  = 8'd0;
        lrc_sum_next        = 8'd0;
        word_high_byte_next = 8'd0;
        first_error_next    = ST_OK;
        wait_counter_next   = 16'd0;
      end else if (armed) begin
        unique case (q_item.cls)
          CLS_TICK: begin
            if (wait_counter >= cfg.timeout_ms) begin
              armed_next    = 1'b0;
              in_frame_next = 1'b0;
              res_valid     = 1'b1;
              res_is_status = 1'b1;
              res_status    = ST_TIMEOUT;
            end else if (wait_counter != 16'hFFFF) begin
              wait_counter_next = wait_counter + 16'd1;
            end
          end
          CLS_COLON: begin
            in_frame_next       = 1'b1;
            nibble_pending_next = 1'b0;
            framing_bad_next    = 1'b0;
            high_nibble_next    = 4'd0;
            byte_position_next  = 8'd0;
            lrc_sum_next        = 8'd0;
            word_high_byte_next = 8'd0;
            first_error_next    = ST_OK;
          end
          CLS_LF: begin
            armed_next    = 1'b0;
            in_frame_next = 1'b0;
            res_valid     = 1'b1;
            res_is_status = 1'b1;
            if (!in_frame || framing_bad || nibble_pending || len_bad) begin
              res_status = ST_FRAMING;
            end else if (first_error != ST_OK) begin
              res_status = first_error;
            end else begin
              res_status = (lrc_sum != 8'd0) ? ST_LRC : ST_OK;
            end
          end
          CLS_BAD: begin
            if (in_frame) framing_bad_next = 1'b1;
          end
          CLS_HEX: begin
            if (in_frame) begin
              if (!nibble_pending) begin
                high_nibble_next    = q_item.nib;
                nibble_pending_next = 1'b1;
              end else begin
                nibble_pending_next = 1'b0;
                lrc_sum_next        = lrc_sum + b;
                if (byte_position != 8'hFF) byte_position_next = byte_position + 8'd1;
                if (byte_position == 8'd0) begin
                  if (b != cfg.expected_slave && first_error == ST_OK)
                    first_error_next = ST_SLAVE;
                end else if (byte_position == 8'd1) begin
                  if (b != cfg.expected_function && first_error == ST_OK)
                    first_error_next = ST_FUNC;
                end else if (!cfg.response_kind) begin
                  if (byte_position == 8'd2) begin
                    if ((!q_ok || {8'd0, b} != {q[14:0], 1'b0}) && first_error == ST_OK)
                      first_error_next = ST_ECHO;
                  end else if (q_ok &&
                               {1'b0, byte_position} < 9'd3 + {q[7:0], 1'b0}) begin
                    if (!p_off[0]) begin
                      word_high_byte_next = b;
                    end else if (first_error == ST_OK) begin
                      res_valid = 1'b1;
                      res_word  = {word_high_byte, b};
                      res_index = p_off[7:1];
                    end
                  end
                end else begin
                  // write echo: register address at bytes 2-3, second word at 4-5
                  if (byte_position == 8'd2 || byte_position == 8'd4) begin
                    word_high_byte_next = b;
                  end else if (byte_position == 8'd3) begin
                    if ({word_high_byte, b} != cfg.expected_register &&
                        first_error == ST_OK)
                      first_error_next = ST_ECHO;
                  end else if (byte_position == 8'd5) begin
                    if ({word_high_byte, b} != q && first_error == ST_OK)
                      first_error_next = ST_ECHO;
                  end
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed          <= 1'b0;
      in_frame       <= 1'b0;
      nibble_pending <= 1'b0;
      high_nibble    <= 4'd0;
      byte_position  <= 8'd0;
      lrc_sum        <= 8'd0;
      word_high_byte <= 8'd0;
      first_error    <= ST_OK;
      framing_bad    <= 1'b0;
      wait_counter   <= 16'd0;
      out_valid      <= 1'b0;
    end else begin
      armed          <= armed_next;
      in_frame       <= in_frame_next;
      nibble_pending <= nibble_pending_next;
      high_nibble    <= high_nibble_next;
      byte_position  <= byte_position_next;
      lrc_sum        <= lrc_sum_next;
      word_high_byte <= word_high_byte_next;
      first_error    <= first_error_next;
      framing_bad    <= framing_bad_next;
      wait_counter   <= wait_counter_next;
      if (q_pop) begin
        out_valid <= res_valid;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res_valid) begin
      rsp.is_status  <= res_is_status;
      rsp.word_value <= res_word;
      rsp.word_index <= res_index;
      rsp.status     <= res_status;
      rsp.last       <= res_is_status;
    end
  end

  assign rsp.valid = out_valid;

endmodule

// ===== rtl/modbus_ascii_response_checker_unit.sv =====
// Top level of the Modbus ASCII response checker: config registers and wiring.
//
//   channel  dir  payload                                            handshake
//   req      in   req_type[1:0], rx_char[7:0]                        valid/ready
//   rsp      out  is_status, word_value[15:0], word_index[6:0],      valid/ready
//                 status[2:0], last
//   cfg      in   cfg_index[2:0], cfg_data[15:0]                     cfg_we
//
// The queue takes one request beat per cycle while it has room; an accepted beat lands in
// the two-entry queue and is then decoded into the result register, which drives rsp.valid.
// The decoder retires one beat per cycle whenever its output register is free
// or being drained; a stalled rsp backs up into the queue, then into req.ready.
// Synchronous reset clears the queue, the decoder and the config to defaults.
`timescale 1ns / 1ps

module modbus_ascii_response_checker_unit import mbrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mbrc_in_if.sink     req,
  mbrc_out_if.source  rsp,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t  cfg;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_slave          <= 8'd1;
      cfg.expected_function       <= 8'd3;
      cfg.response_kind           <= 1'b0;
      cfg.expected_count_or_value <= 16'd1;
      cfg.expected_register       <= 16'd0;
      cfg.timeout_ms              <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLAVE:    cfg.expected_slave          <= cfg_data[7:0];
        REG_FUNCTION: cfg.expected_function       <= cfg_data[7:0];
        REG_KIND:     cfg.response_kind           <= cfg_data[0];
        REG_COUNT:    cfg.expected_count_or_value <= cfg_data;
        REG_REGISTER: cfg.expected_register       <= cfg_data;
        REG_TIMEOUT:  cfg.timeout_ms              <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mbrc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  mbrc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the Modbus ASCII response checker: random frames, mirror model, stalls.
`timescale 1ns / 1ps

module tb_top import mbrc_pkg::*; ();

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int NUM_PHASES   = 12;
  localparam int PRINT_CAP    = 40;
  localparam int HOLD_CYCLES  = 150;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
  } req_beat_t;

  typedef struct packed {
    logic        is_status;
    logic [15:0] word_value;
    logic [6:0]  word_index;
    logic [2:0]  status;
    logic        last;
  } rsp_beat_t;

  typedef enum int {
    DMG_NONE,
    DMG_LRC,
    DMG_BADCHAR,
    DMG_ODD,
    DMG_SHORT,
    DMG_LONG,
    DMG_RESTART
  } frame_damage_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  mbrc_in_if  req_ch ();
  mbrc_out_if rsp_ch ();

  modbus_ascii_response_checker_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  req_beat_t pending_reqs[$];
  rsp_beat_t awaited_beats[$];

  int n_pushed      = 0;
  int n_accepted    = 0;
  int mismatches    = 0;
  int cycles_run    = 0;
  int burst_left    = 1;
  int gap_left      = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int stall_left    = 0;
  int rdy_mode      = 0;

  req_beat_t next_req;
  rsp_beat_t head_beat;

  // mirror of the checker's registers and frame state
  cfg_t        cfg_m;
  logic        armed_m;
  logic        in_frame_m;
  logic        nib_pend_m;
  logic        framing_bad_m;
  logic [3:0]  hi_nib_m;
  logic [7:0]  byte_pos_m;
  logic [7:0]  lrc_m;
  logic [7:0]  word_hi_m;
  logic [2:0]  first_err_m;
  logic [15:0] wait_cnt_m;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h41 + 8'(n) - 8'd10;
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic clear_frame();
    in_frame_m    = 1'b1;
    nib_pend_m    = 1'b0;
    framing_bad_m = 1'b0;
    hi_nib_m      = '0;
    byte_pos_m    = '0;
    lrc_m         = '0;
    word_hi_m     = '0;
    first_err_m   = ST_OK;
  endtask

  task automatic retire_with(input logic [2:0] code);
    rsp_beat_t beat;
    beat.is_status  = 1'b1;
    beat.word_value = '0;
    beat.word_index = '0;
    beat.status     = code;
    beat.last       = 1'b1;
    awaited_beats.push_back(beat);
    armed_m    = 1'b0;
    in_frame_m = 1'b0;
  endtask

  task automatic latch_error(input logic [2:0] code);
    if (first_err_m == ST_OK) begin
      first_err_m = code;
    end
  endtask

  // Advances the mirror by one accepted request beat and queues what it should produce.
  task automatic track_request(input logic [1:0] kind, input logic [7:0] ch);
    logic [7:0] b;
    logic [3:0] nib;
    logic       is_hex;
    int         pi;
    int         q;
    int         want;
    rsp_beat_t  beat;
    is_hex = 1'b1;
    nib    = '0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      nib = 4'(ch - 8'h30);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      nib = 4'(ch - 8'h41 + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
    q = int'(cfg_m.expected_count_or_value);
    if (kind == REQ_ARM) begin
      clear_frame();
      in_frame_m = 1'b0;
      armed_m    = 1'b1;
      wait_cnt_m = '0;
    end else if (!armed_m || (kind != REQ_CHAR && kind != REQ_TICK)) begin
      // ignored
    end else if (kind == REQ_TICK) begin
      if (wait_cnt_m >= cfg_m.timeout_ms) begin
        retire_with(ST_TIMEOUT);
      end else if (wait_cnt_m != 16'hFFFF) begin
        wait_cnt_m = wait_cnt_m + 16'd1;
      end
    end else if (ch == CH_COLON) begin
      clear_frame();
    end else if (ch == CH_LF) begin
      if (!in_frame_m) begin
        retire_with(ST_FRAMING);
      end else begin
        want = cfg_m.response_kind ? 7 : 4 + 2 * q;
        if (framing_bad_m || nib_pend_m || int'(byte_pos_m) != want) begin
          retire_with(ST_FRAMING);
        end else if (first_err_m != ST_OK) begin
          retire_with(first_err_m);
        end else begin
          retire_with((lrc_m != 8'd0) ? ST_LRC : ST_OK);
        end
      end
    end else if (!in_frame_m || ch == CH_CR) begin
      // ignored
    end else if (!is_hex) begin
      framing_bad_m = 1'b1;
    end else if (!nib_pend_m) begin
      hi_nib_m   = nib;
      nib_pend_m = 1'b1;
    end else begin
      nib_pend_m = 1'b0;
      b          = {hi_nib_m, nib};
      pi         = int'(byte_pos_m);
      lrc_m      = lrc_m + b;
      if (pi == 0) begin
        if (b != cfg_m.expected_slave) latch_error(ST_SLAVE);
      end else if (pi == 1) begin
        if (b != cfg_m.expected_function) latch_error(ST_FUNC);
      end else if (cfg_m.response_kind == 1'b0) begin
        if (pi == 2) begin
          if (q < 1 || q > MaxWords || int'(b) != 2 * q) latch_error(ST_ECHO);
        end else if (q >= 1 && q <= MaxWords && pi < 3 + 2 * q) begin
          if (((pi - 3) % 2) == 0) begin
            word_hi_m = b;
          end else if (first_err_m == ST_OK) begin
            beat.is_status  = 1'b0;
            beat.word_value = {word_hi_m, b};
            beat.word_index = 7'((pi - 3) / 2);
            beat.status     = ST_OK;
            beat.last       = 1'b0;
            awaited_beats.push_back(beat);
          end
        end
      end else begin
        if (pi == 2 || pi == 4) begin
          word_hi_m = b;
        end else if (pi == 3) begin
          if ({word_hi_m, b} != cfg_m.expected_register) latch_error(ST_ECHO);
        end else if (pi == 5) begin
          if ({word_hi_m, b} != cfg_m.expected_count_or_value) latch_error(ST_ECHO);
        end
      end
      if (byte_pos_m != 8'hFF) byte_pos_m = byte_pos_m + 8'd1;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int exp);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, exp);
    end
  endtask

  task automatic push_item(input logic [1:0] kind, input logic [7:0] ch);
    req_beat_t item;
    item.kind = kind;
    item.ch   = ch;
    pending_reqs.push_back(item);
    n_pushed++;
  endtask

  // ':' + hex pairs + LRC + optional CR + LF, with one optional defect and stray ticks
  task automatic push_frame(input logic [7:0] body[$], input frame_damage_t dmg,
                            input int tick_pct);
    logic [7:0] chars[$];
    logic [7:0] byte_sum;
    logic [7:0] bad;
    if (dmg == DMG_SHORT && body.size() != 0) void'(body.pop_back());
    if (dmg == DMG_LONG) body.push_back(8'($urandom));
    byte_sum = '0;
    foreach (body[i]) byte_sum = byte_sum + body[i];
    byte_sum = ~byte_sum + 8'd1;
    if (dmg == DMG_LRC) byte_sum = byte_sum + 8'($urandom_range(1, 255));
    body.push_back(byte_sum);
    if (dmg == DMG_RESTART) begin
      chars.push_back(CH_COLON);
      repeat ($urandom_range(1, 5)) chars.push_back(hex_char(4'($urandom)));
    end
    chars.push_back(CH_COLON);
    foreach (body[i]) begin
      chars.push_back(hex_char(body[i][7:4]));
      chars.push_back(hex_char(body[i][3:0]));
    end
    if (dmg == DMG_ODD) chars.delete($urandom_range(1, chars.size() - 1));
    if (dmg == DMG_BADCHAR) begin
      if ($urandom_range(0, 2) == 0) begin
        bad = 8'h61 + 8'($urandom_range(0, 5));
      end else begin
        bad = 8'($urandom);
        while ((bad >= 8'h30 && bad <= 8'h39) || (bad >= 8'h41 && bad <= 8'h46) ||
               bad == CH_CR || bad == CH_LF || bad == CH_COLON) begin
          bad = 8'($urandom);
        end
      end
      chars[$urandom_range(1, chars.size() - 1)] = bad;
    end
    if ($urandom_range(0, 9) == 0) chars.insert($urandom_range(1, chars.size()), CH_CR);
    if ($urandom_range(0, 4) != 0) chars.push_back(CH_CR);
    chars.push_back(CH_LF);
    foreach (chars[i]) begin
      if (tick_pct != 0 && $urandom_range(1, 100) <= tick_pct) begin
        push_item(REQ_TICK, 8'($urandom));
      end
      push_item(REQ_CHAR, chars[i]);
    end
  endtask

  // Mostly well-formed responses against the current settings, some noise and damage.
  task automatic gen_transaction();
    logic [7:0]    body[$];
    logic [15:0]   w;
    int            q;
    int            nwords;
    int            tick_pct;
    frame_damage_t dmg;
    q = int'(cfg_m.expected_count_or_value);
    if ($urandom_range(0, 19) != 0) push_item(REQ_ARM, 8'($urandom));
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 4)) push_item(REQ_CHAR, 8'($urandom));
    end
    if (cfg_m.timeout_ms <= 16'd16 && $urandom_range(0, 9) == 0) begin
      repeat (int'(cfg_m.timeout_ms) + 1) push_item(REQ_TICK, 8'($urandom));
    end else begin
      body.push_back(($urandom_range(0, 6) != 0) ? cfg_m.expected_slave : 8'($urandom));
      body.push_back(($urandom_range(0, 6) != 0) ? cfg_m.expected_function : 8'($urandom));
      if (cfg_m.response_kind == 1'b0) begin
        nwords = (q >= 1 && q <= 8) ? q : $urandom_range(0, 3);
        if ($urandom_range(0, 9) == 0) nwords = $urandom_range(0, 3);
        body.push_back(($urandom_range(0, 6) != 0) ? 8'(2 * q) : 8'($urandom));
        repeat (nwords) begin
          w = rand_word();
          body.push_back(w[15:8]);
          body.push_back(w[7:0]);
        end
      end else begin
        w = ($urandom_range(0, 6) != 0) ? cfg_m.expected_register : rand_word();
        body.push_back(w[15:8]);
        body.push_back(w[7:0]);
        w = ($urandom_range(0, 6) != 0) ? cfg_m.expected_count_or_value : rand_word();
        body.push_back(w[15:8]);
        body.push_back(w[7:0]);
      end
      dmg      = ($urandom_range(0, 99) < 65) ? DMG_NONE : frame_damage_t'($urandom_range(1, 6));
      tick_pct = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(3, 10);
      push_frame(body, dmg, tick_pct);
    end
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_SLAVE:    cfg_m.expected_slave          = val[7:0];
      REG_FUNCTION: cfg_m.expected_function       = val[7:0];
      REG_KIND:     cfg_m.response_kind           = val[0];
      REG_COUNT:    cfg_m.expected_count_or_value = val;
      REG_REGISTER: cfg_m.expected_register       = val;
      REG_TIMEOUT:  cfg_m.timeout_ms              = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // all beats handed over and answered, then let the pipeline settle
  task automatic wait_idle();
    while (n_accepted != n_pushed || awaited_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // request driver: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        track_request(req_ch.req_type, req_ch.rx_char);
        n_accepted++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          next_req = pending_reqs.pop_front();
          req_ch.valid    <= 1'b1;
          req_ch.req_type <= next_req.kind;
          req_ch.rx_char  <= next_req.ch;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response ready: modes of free flow, light and heavy stalls, plus long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        stall_left  = HOLD_CYCLES;
      end
      if ($urandom_range(0, 63) == 0) rdy_mode = $urandom_range(0, 2);
      if (stall_left != 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (rdy_mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_beats.size() == 0) begin
        report_mismatch("beat with none awaited, status", int'(rsp_ch.status), 0);
      end else begin
        head_beat = awaited_beats.pop_front();
        if (rsp_ch.is_status !== head_beat.is_status) begin
          report_mismatch("is_status", int'(rsp_ch.is_status), int'(head_beat.is_status));
        end
        if (rsp_ch.word_value !== head_beat.word_value) begin
          report_mismatch("word_value", int'(rsp_ch.word_value),
                          int'(head_beat.word_value));
        end
        if (rsp_ch.word_index !== head_beat.word_index) begin
          report_mismatch("word_index", int'(rsp_ch.word_index),
                          int'(head_beat.word_index));
        end
        if (rsp_ch.status !== head_beat.status) begin
          report_mismatch("status", int'(rsp_ch.status), int'(head_beat.status));
        end
        if (rsp_ch.last !== head_beat.last) begin
          report_mismatch("last", int'(rsp_ch.last), int'(head_beat.last));
        end
      end
    end
  end

  initial begin
    logic [7:0]  body[$];
    logic [7:0]  slave;
    logic [7:0]  func;
    logic        kind;
    logic [15:0] qv;
    logic [15:0] reg_addr;
    logic [15:0] tmo;
    logic [15:0] w;
    int          start_count;

    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = REG_SLAVE;
    cfg_data        = '0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_ARM;
    req_ch.rx_char  = '0;
    rsp_ch.ready    = 1'b0;

    cfg_m.expected_slave          = 8'd1;
    cfg_m.expected_function       = 8'd3;
    cfg_m.response_kind           = 1'b0;
    cfg_m.expected_count_or_value = 16'd1;
    cfg_m.expected_register       = 16'd0;
    cfg_m.timeout_ms              = 16'd1000;
    armed_m       = 1'b0;
    in_frame_m    = 1'b0;
    nib_pend_m    = 1'b0;
    framing_bad_m = 1'b0;
    hi_nib_m      = '0;
    byte_pos_m    = '0;
    lrc_m         = '0;
    word_hi_m     = '0;
    first_err_m   = ST_OK;
    wait_cnt_m    = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed, reset settings: idle traffic, stray LF, re-arm, colon restart, good read
    push_item(REQ_TICK, 8'h00);
    push_item(REQ_CHAR, hex_char(4'hA));
    push_item(REQ_ARM, 8'h00);
    push_item(REQ_CHAR, CH_LF);
    push_item(REQ_ARM, 8'h00);
    push_item(REQ_ARM, 8'hFF);
    push_item(REQ_CHAR, CH_COLON);
    push_item(REQ_CHAR, hex_char(4'h7));
    body = '{8'h01, 8'h03, 8'h02, 8'hFF, 8'hFF};
    push_frame(body, DMG_NONE, 0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      if (ph == 0) begin
        slave = 8'd0; func = 8'd0; kind = 1'b0;
        qv = 16'(MaxWords); reg_addr = 16'd0; tmo = 16'd1;
      end else if (ph == 1) begin
        slave = 8'hFF; func = 8'hFF; kind = 1'b1;
        qv = 16'hFFFF; reg_addr = 16'hFFFF; tmo = 16'hFFFF;
      end else begin
        slave = ($urandom_range(0, 1) != 0) ? 8'd1 : 8'($urandom);
        case ($urandom_range(0, 4))
          0: func = 8'd3;
          1: func = 8'd4;
          2: func = 8'd6;
          3: func = 8'd16;
          default: func = 8'($urandom);
        endcase
        kind = 1'($urandom);
        if (kind == 1'b0) begin
          case ($urandom_range(0, 9))
            0: qv = 16'd0;
            1: qv = 16'($urandom_range(MaxWords + 1, 65535));
            2, 3: qv = 16'($urandom_range(5, 8));
            default: qv = 16'($urandom_range(1, 4));
          endcase
        end else begin
          qv = rand_word();
        end
        reg_addr = rand_word();
        case ($urandom_range(0, 9))
          0, 1, 2, 3: tmo = 16'($urandom_range(1, 12));
          4, 5, 6: tmo = 16'd1000;
          default: tmo = 16'($urandom_range(13, 65535));
        endcase
      end
      set_reg(REG_SLAVE, {8'd0, slave});
      set_reg(REG_FUNCTION, {8'd0, func});
      set_reg(REG_KIND, {15'd0, kind});
      set_reg(REG_COUNT, qv);
      set_reg(REG_REGISTER, reg_addr);
      set_reg(REG_TIMEOUT, tmo);

      // long receiver hold-off while the sender keeps offering beats
      if (ph == 0 || ph == 6) hold_requests++;

      if (ph == 0) begin
        // full-size read: every word index up to the last
        body = '{slave, func, 8'(2 * MaxWords)};
        repeat (MaxWords) begin
          w = rand_word();
          body.push_back(w[15:8]);
          body.push_back(w[7:0]);
        end
        push_item(REQ_ARM, 8'h00);
        push_frame(body, DMG_NONE, 0);
      end else if (ph == 1) begin
        body = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        push_item(REQ_ARM, 8'h00);
        push_frame(body, DMG_NONE, 0);
      end

      start_count = n_pushed;
      while (n_pushed - start_count < ((ph < 2) ? 10 : 15)) gen_transaction();
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mbrc_pkg.sv
rtl/mbrc_if.sv
rtl/mbrc_front.sv
rtl/mbrc_back.sv
rtl/modbus_ascii_response_checker_unit.sv
tb/sv/tb_top.sv
